// ----- hw/rtl/contiguous_extent_grow_allocator_core_defines.svh -----
// Assertion macros for the contiguous extent grow allocator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef CONTIGUOUS_EXTENT_GROW_ALLOCATOR_CORE_DEFINES_SVH
`define CONTIGUOUS_EXTENT_GROW_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define CEG_ASSERT_HOLDS(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define CEG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ceg_pkg.sv -----
// Shared constants and types of the contiguous extent grow allocator.
// No dependencies; used by ceg_word_unit and the top level.
package ceg_pkg;

    localparam int MAP_BLOCKS_DEF       = 4096;
    localparam int BLOCK_BYTES_LOG2_DEF = 12;

    localparam int WORD_BITS  = 8;
    localparam int WORD_SHIFT = 3;

    localparam int CFG_W     = 13;
    localparam int CFG_RESET = 4096;
    localparam int START_W   = 12;
    localparam int COUNT_W   = 13;
    localparam int BYTES_W   = 25;
    localparam int STATUS_W  = 2;

    localparam logic [STATUS_W-1:0] ST_UNCHANGED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GROWN     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RELOCATED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOSPACE   = 2'd3;

    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_FIT   = 2'd3;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic                  conflict;
        logic                  found;
        logic [WORD_SHIFT-1:0] found_bit;
    } unit_flags_t;

endpackage

// ----- hw/rtl/ceg_word_unit.sv -----
// Shared word unit: checks, sets or clears a block range in one map word,
// or advances the first-fit free-run count over it. Depends on ceg_pkg.
module ceg_word_unit #(
    parameter int IDX_W  = 13,
    parameter int ADDR_W = 9
) (
    input  logic [1:0]          op,
    input  ceg_pkg::word_t      rd_word,
    input  logic [ADDR_W-1:0]   word_addr,
    input  logic [IDX_W-1:0]    lo,
    input  logic [IDX_W-1:0]    hi,
    input  logic [IDX_W-1:0]    lim,
    input  logic [IDX_W-1:0]    need,
    input  logic [IDX_W-1:0]    run_in,
    output ceg_pkg::word_t      wr_word,
    output logic [IDX_W-1:0]    run_out,
    output ceg_pkg::unit_flags_t flags
);

    always_comb
    begin
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] run;
        logic             used;
        ceg_pkg::word_t   mask;
        mask  = '0;
        run   = run_in;
        flags = '0;
        for (int b = 0; b < ceg_pkg::WORD_BITS; b++)
        begin
            idx     = IDX_W'({word_addr, ceg_pkg::WORD_SHIFT'(b)});
            mask[b] = (idx >= lo) && (idx < hi);
            if (mask[b] && rd_word[b])
            begin
                flags.conflict = 1'b1;
            end
            // blocks at or past the limit break a free run
            used = rd_word[b] || (idx >= lim);
            if (!flags.found)
            begin
                if (used)
                begin
                    run = '0;
                end
                else
                begin
                    run = run + 1'b1;
                end
                if (!used && run == need)
                begin
                    flags.found     = 1'b1;
                    flags.found_bit = ceg_pkg::WORD_SHIFT'(b);
                end
            end
        end
        run_out = run;
        unique case (op)
            ceg_pkg::OP_SET:   wr_word = rd_word | mask;
            ceg_pkg::OP_CLEAR: wr_word = rd_word & ~mask;
            ceg_pkg::OP_CHECK: wr_word = rd_word;
            ceg_pkg::OP_FIT:   wr_word = rd_word;
            default:           wr_word = rd_word;
        endcase
    end

endmodule

// ----- hw/rtl/contiguous_extent_grow_allocator_core.sv -----
// Top level of the contiguous extent grow allocator: sequencer, used map
// memory and result register. Depends on ceg_pkg, ceg_word_unit and the defines header.
//
// Usage:
//   Requests arrive as words on the s_axis channel (extent start/count, write
//   offset/size); one result word per request leaves on m_axis (status, new
//   start, new count). The user must set the number of usable blocks through
//   cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
//   The used map lives in a memory of 8-block words. Every pass walks it one
//   word per cycle through the shared word unit, behind a registered read.
//   Per request: sizing and decision (S_CALC, S_DEC), then up to four passes:
//   in-place check and grow over the words past the extent, first-fit scan
//   over ceil(limit/8) words (512 at 4096 blocks), free of the old extent,
//   mark of the new run. A request left unchanged runs no pass.
//   After reset the map is swept clear, one word per cycle over its MAP_BLOCKS/8
//   words (512 by default); s_axis_tready stays low meanwhile.
//   A finished result waits in the output register; a new request is taken
//   while it waits, and the next result holds in the done state until the
//   receiver takes the previous one.
`include "contiguous_extent_grow_allocator_core_defines.svh"

module contiguous_extent_grow_allocator_core #(
    parameter int MAP_BLOCKS       = ceg_pkg::MAP_BLOCKS_DEF,
    parameter int BLOCK_BYTES_LOG2 = ceg_pkg::BLOCK_BYTES_LOG2_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,       // blocks_in_use
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] extent_start, [24:12] extent_count, [49:25] write_offset,
    // [74:50] write_size, [79:75] zero
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [13:2] new_start, [26:14] new_count, [31:27] zero
    output logic [31:0] m_axis_tdata
);

    localparam int N_W   = $clog2(MAP_BLOCKS) + 1;
    localparam int WORDS = (MAP_BLOCKS + ceg_pkg::WORD_BITS - 1) / ceg_pkg::WORD_BITS;
    localparam int A_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SUM_W = ceg_pkg::BYTES_W + 2;
    localparam int TOT_W = SUM_W - BLOCK_BYTES_LOG2;
    localparam int P_M   = (TOT_W > ceg_pkg::COUNT_W) ? TOT_W : ceg_pkg::COUNT_W;
    localparam int P_W   = ((P_M > N_W) ? P_M : N_W) + 1;
    localparam logic [SUM_W-1:0] ROUND_UP = SUM_W'((1 << BLOCK_BYTES_LOG2) - 1);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CALC  = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_GROW  = 4'd5;
    localparam logic [3:0] S_FIT   = 4'd6;
    localparam logic [3:0] S_RELOC = 4'd7;
    localparam logic [3:0] S_FREE  = 4'd8;
    localparam logic [3:0] S_MARK  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    // control state
    logic [3:0]             state_reg, state_next;
    logic [ceg_pkg::CFG_W-1:0] biu_reg;
    logic [A_W-1:0]         issue_addr_reg, issue_addr_next;
    logic [A_W-1:0]         last_reg, last_next;
    logic                   issue_on_reg, issue_on_next;
    logic                   pipe_vld_reg, pipe_vld_next;
    logic                   out_vld_reg, out_vld_next;

    // payload
    logic [ceg_pkg::START_W-1:0] ext_start_reg, ext_start_next;
    logic [ceg_pkg::COUNT_W-1:0] ext_count_reg, ext_count_next;
    logic [ceg_pkg::BYTES_W-1:0] wr_off_reg, wr_off_next;
    logic [ceg_pkg::BYTES_W-1:0] wr_size_reg, wr_size_next;
    logic [TOT_W-1:0]       total_reg, total_next;
    logic [N_W-1:0]         lo_reg, lo_next;
    logic [N_W-1:0]         hi_reg, hi_next;
    logic [N_W-1:0]         run_reg, run_next;
    logic [N_W-1:0]         where_reg, where_next;
    logic [A_W-1:0]         pipe_addr_reg, pipe_addr_next;
    logic [ceg_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ceg_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ceg_pkg::START_W-1:0]  out_start_reg, out_start_next;
    logic [ceg_pkg::COUNT_W-1:0]  out_count_reg, out_count_next;
    ceg_pkg::word_t         rdata_reg;

    // used map memory
    ceg_pkg::word_t         map_mem [WORDS];
    logic                   mem_we, mem_re;
    logic [A_W-1:0]         mem_waddr, mem_raddr;
    ceg_pkg::word_t         mem_wdata;

    // shared unit
    logic [1:0]             unit_op;
    ceg_pkg::word_t         unit_wr;
    logic [N_W-1:0]         unit_run;
    ceg_pkg::unit_flags_t   unit_flags;
    logic [N_W-1:0]         lim;
    logic [N_W-1:0]         need;

    // usable limit: the smaller of the register and the map size
    always_comb
    begin
        if (32'(biu_reg) < 32'(MAP_BLOCKS))
        begin
            lim = N_W'(biu_reg);
        end
        else
        begin
            lim = N_W'(MAP_BLOCKS);
        end
    end

    assign need = N_W'(total_reg);

    always_comb
    begin
        unique case (state_reg)
            S_CHK:          unit_op = ceg_pkg::OP_CHECK;
            S_GROW, S_MARK: unit_op = ceg_pkg::OP_SET;
            S_FREE:         unit_op = ceg_pkg::OP_CLEAR;
            default:        unit_op = ceg_pkg::OP_FIT;
        endcase
    end

    ceg_word_unit #(
        .IDX_W  (N_W),
        .ADDR_W (A_W)
    ) u_word (
        .op        (unit_op),
        .rd_word   (rdata_reg),
        .word_addr (pipe_addr_reg),
        .lo        (lo_reg),
        .hi        (hi_reg),
        .lim       (lim),
        .need      (need),
        .run_in    (run_reg),
        .wr_word   (unit_wr),
        .run_out   (unit_run),
        .flags     (unit_flags)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {5'b0, out_count_reg, out_start_reg, out_status_reg};

    always_comb
    begin
        logic [SUM_W-1:0] sum;
        logic [P_W-1:0]   end_old;
        logic [P_W-1:0]   end_new;
        logic [P_W-1:0]   free_hi;
        logic             start_pass;
        logic             pass_last_word;
        logic [3:0]       pass_state;
        logic [N_W-1:0]   pass_lo;
        logic [N_W-1:0]   pass_hi;
        logic [N_W-1:0]   found_idx;

        state_next      = state_reg;
        issue_addr_next = issue_addr_reg;
        last_next       = last_reg;
        issue_on_next   = issue_on_reg;
        pipe_vld_next   = 1'b0;
        pipe_addr_next  = pipe_addr_reg;
        out_vld_next    = out_vld_reg;
        ext_start_next  = ext_start_reg;
        ext_count_next  = ext_count_reg;
        wr_off_next     = wr_off_reg;
        wr_size_next    = wr_size_reg;
        total_next      = total_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        run_next        = run_reg;
        where_next      = where_reg;
        res_status_next = res_status_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_count_next  = out_count_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = pipe_addr_reg;
        mem_raddr       = issue_addr_reg;
        mem_wdata       = unit_wr;

        sum       = SUM_W'(wr_off_reg) + SUM_W'(wr_size_reg) + ROUND_UP;
        end_old   = P_W'(ext_start_reg) + P_W'(ext_count_reg);
        end_new   = P_W'(ext_start_reg) + P_W'(total_reg);
        free_hi   = (end_old > P_W'(MAP_BLOCKS)) ? P_W'(MAP_BLOCKS) : end_old;
        found_idx = N_W'({pipe_addr_reg, unit_flags.found_bit});
        start_pass = 1'b0;
        pass_state = state_reg;
        pass_lo    = lo_reg;
        pass_hi    = hi_reg;
        pass_last_word = pipe_vld_reg && (pipe_addr_reg == last_reg);

        // drop the taken result
        if (out_vld_reg && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end

        // issue one map read a cycle while a pass runs
        if (issue_on_reg && state_reg != S_CLR)
        begin
            mem_re         = 1'b1;
            pipe_vld_next  = 1'b1;
            pipe_addr_next = issue_addr_reg;
            if (issue_addr_reg == last_reg)
            begin
                issue_on_next = 1'b0;
            end
            else
            begin
                issue_addr_next = issue_addr_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = issue_addr_reg;
                mem_wdata = '0;
                if (issue_addr_reg == A_W'(WORDS - 1))
                begin
                    issue_addr_next = '0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    issue_addr_next = issue_addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ext_start_next = s_axis_tdata[11:0];
                    ext_count_next = s_axis_tdata[24:12];
                    wr_off_next    = s_axis_tdata[49:25];
                    wr_size_next   = s_axis_tdata[74:50];
                    state_next     = S_CALC;
                end
            end
            S_CALC:
            begin
                total_next = TOT_W'(sum >> BLOCK_BYTES_LOG2);
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (P_W'(total_reg) <= P_W'(ext_count_reg))
                begin
                    res_status_next = ceg_pkg::ST_UNCHANGED;
                    state_next      = S_DONE;
                end
                else if (end_new <= P_W'(lim))
                begin
                    start_pass = 1'b1;
                    pass_state = S_CHK;
                    pass_lo    = N_W'(end_old);
                    pass_hi    = N_W'(end_new);
                end
                else if (P_W'(total_reg) > P_W'(lim))
                begin
                    res_status_next = ceg_pkg::ST_NOSPACE;
                    state_next      = S_DONE;
                end
                else
                begin
                    start_pass = 1'b1;
                    pass_state = S_FIT;
                    pass_lo    = '0;
                    pass_hi    = lim;
                end
            end
            S_CHK:
            begin
                if (pipe_vld_reg && unit_flags.conflict)
                begin
                    // no room past the end: fall back to first fit
                    start_pass = 1'b1;
                    pass_state = S_FIT;
                    pass_lo    = '0;
                    pass_hi    = lim;
                end
                else if (pass_last_word)
                begin
                    start_pass = 1'b1;
                    pass_state = S_GROW;
                end
            end
            S_GROW:
            begin
                mem_we = pipe_vld_reg;
                if (pass_last_word)
                begin
                    res_status_next = ceg_pkg::ST_GROWN;
                    state_next      = S_DONE;
                end
            end
            S_FIT:
            begin
                if (pipe_vld_reg)
                begin
                    run_next = unit_run;
                    if (unit_flags.found)
                    begin
                        where_next    = found_idx + 1'b1 - need;
                        issue_on_next = 1'b0;
                        state_next    = S_RELOC;
                    end
                    else if (pass_last_word)
                    begin
                        res_status_next = ceg_pkg::ST_NOSPACE;
                        state_next      = S_DONE;
                    end
                end
            end
            S_RELOC:
            begin
                start_pass = 1'b1;
                if (P_W'(ext_start_reg) < free_hi)
                begin
                    pass_state = S_FREE;
                    pass_lo    = N_W'(ext_start_reg);
                    pass_hi    = N_W'(free_hi);
                end
                else
                begin
                    pass_state = S_MARK;
                    pass_lo    = where_reg;
                    pass_hi    = where_reg + need;
                end
            end
            S_FREE:
            begin
                mem_we = pipe_vld_reg;
                if (pass_last_word)
                begin
                    start_pass = 1'b1;
                    pass_state = S_MARK;
                    pass_lo    = where_reg;
                    pass_hi    = where_reg + need;
                end
            end
            S_MARK:
            begin
                mem_we = pipe_vld_reg;
                if (pass_last_word)
                begin
                    res_status_next = ceg_pkg::ST_RELOCATED;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_start_next  = ext_start_reg;
                    out_count_next  = ext_count_reg;
                    if (res_status_reg == ceg_pkg::ST_GROWN)
                    begin
                        out_count_next = ceg_pkg::COUNT_W'(total_reg);
                    end
                    else if (res_status_reg == ceg_pkg::ST_RELOCATED)
                    begin
                        out_start_next = ceg_pkg::START_W'(where_reg);
                        out_count_next = ceg_pkg::COUNT_W'(total_reg);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // launch a pass over words lo/8 .. (hi-1)/8
        if (start_pass)
        begin
            state_next      = pass_state;
            lo_next         = pass_lo;
            hi_next         = pass_hi;
            issue_addr_next = A_W'(pass_lo >> ceg_pkg::WORD_SHIFT);
            last_next       = A_W'((pass_hi - 1'b1) >> ceg_pkg::WORD_SHIFT);
            issue_on_next   = 1'b1;
            pipe_vld_next   = 1'b0;
            run_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            biu_reg        <= ceg_pkg::CFG_W'(ceg_pkg::CFG_RESET);
            issue_addr_reg <= '0;
            last_reg       <= '0;
            issue_on_reg   <= 1'b0;
            pipe_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_addr_reg <= issue_addr_next;
            last_reg       <= last_next;
            issue_on_reg   <= issue_on_next;
            pipe_vld_reg   <= pipe_vld_next;
            out_vld_reg    <= out_vld_next;
            if (cfg_we)
            begin
                biu_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ext_start_reg  <= ext_start_next;
        ext_count_reg  <= ext_count_next;
        wr_off_reg     <= wr_off_next;
        wr_size_reg    <= wr_size_next;
        total_reg      <= total_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        run_reg        <= run_next;
        where_reg      <= where_next;
        pipe_addr_reg  <= pipe_addr_next;
        res_status_reg <= res_status_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        out_count_reg  <= out_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= map_mem[mem_raddr];
        end
    end

    `CEG_ASSERT_NEXT(a_accept_sizes, s_axis_tvalid && s_axis_tready, state_reg == S_CALC,
        "accepted request did not start sizing")
    `CEG_ASSERT_HOLDS(a_write_in_pass, mem_we, state_reg == S_CLR || state_reg == S_GROW ||
        state_reg == S_FREE || state_reg == S_MARK, "map written outside a write pass")
    `CEG_ASSERT_NEXT(a_done_holds, state_reg == S_DONE && out_vld_reg && !m_axis_tready,
        state_reg == S_DONE && out_vld_reg, "pending result lost while receiver stalled")

endmodule

// ----- dv/contiguous_extent_grow_allocator_core_tb.sv -----
// Testbench for contiguous_extent_grow_allocator_core: grow, relocate and no-space checks.
// Depends on ceg_pkg and the RTL only. It predicts each result from its own copy of the
// used map and compares the result words with a queue of expected extents.
`timescale 1ns / 100ps

module contiguous_extent_grow_allocator_core_tb;

    localparam int NUM_BLOCKS = 4096;
    localparam int IDLE_PCT   = 21;
    localparam int STALL_MAX  = 20000;
    localparam int NUM_FILES  = 6;

    typedef struct {
        logic [ceg_pkg::STATUS_W-1:0] status;
        logic [ceg_pkg::START_W-1:0]  new_start;
        logic [ceg_pkg::COUNT_W-1:0]  new_count;
    } extent_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [12:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    // Shadow state of the block: the used map and the usable block register.
    bit          used_map [NUM_BLOCKS];
    logic [12:0] block_limit;

    extent_result_t expected_extents[$];

    // File table: extents that the random part keeps growing.
    logic [ceg_pkg::START_W-1:0] file_start [NUM_FILES];
    logic [ceg_pkg::COUNT_W-1:0] file_count [NUM_FILES];

    bit calm;          // true while neither side idles
    int errors;
    int results_seen;
    int status_hits [4];
    int phases_run;
    int stall_cycles;

    contiguous_extent_grow_allocator_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // A block is used when it is marked or at or past the usable limit.
    function automatic bit block_taken(int idx, int lim);
        if (idx >= lim)
            return 1'b1;
        return used_map[idx];
    endfunction

    // Work out the result of one request and update the shadow map.
    task automatic grow_extent(input logic [11:0] st, input logic [12:0] ct,
                               input logic [24:0] off, input logic [24:0] sz,
                               output extent_result_t res);
        int     lim;
        int     total;
        int     extra;
        int     run_len;
        int     where;
        bit     fits;
        bit     found;
        longint bytes;
        lim   = (block_limit < NUM_BLOCKS) ? int'(block_limit) : NUM_BLOCKS;
        bytes = longint'(off) + longint'(sz);
        total = int'((bytes + 4095) >> 12);
        res.status    = ceg_pkg::ST_UNCHANGED;
        res.new_start = st;
        res.new_count = ct;
        if (total > int'(ct)) begin
            extra = total - int'(ct);
            fits  = 1'b1;
            for (int i = 0; i < extra; i++) begin
                if (block_taken(int'(st) + int'(ct) + i, lim)) begin
                    fits = 1'b0;
                    break;
                end
            end
            if (fits) begin
                // Grow in place over the blocks just past the end.
                for (int i = 0; i < extra; i++)
                    used_map[int'(st) + int'(ct) + i] = 1'b1;
                res.status    = ceg_pkg::ST_GROWN;
                res.new_count = total[12:0];
            end
            else begin
                // First fit; the old extent still counts as used here.
                found   = 1'b0;
                run_len = 0;
                where   = 0;
                if (total <= lim) begin
                    for (int i = 0; i < lim; i++) begin
                        if (used_map[i])
                            run_len = 0;
                        else begin
                            run_len++;
                            if (run_len == total) begin
                                where = i + 1 - total;
                                found = 1'b1;
                                break;
                            end
                        end
                    end
                end
                if (found) begin
                    for (int i = 0; i < int'(ct); i++)
                        if (int'(st) + i < NUM_BLOCKS)
                            used_map[int'(st) + i] = 1'b0;
                    for (int i = 0; i < total; i++)
                        used_map[where + i] = 1'b1;
                    res.status    = ceg_pkg::ST_RELOCATED;
                    res.new_start = where[11:0];
                    res.new_count = total[12:0];
                end
                else
                    res.status = ceg_pkg::ST_NOSPACE;
            end
        end
    endtask

    // Send one request word and predict its result once it is taken.
    task automatic send_request(input logic [11:0] st, input logic [12:0] ct,
                                input logic [24:0] off, input logic [24:0] sz,
                                output extent_result_t res);
        @(negedge clk);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {5'd0, sz, off, ct, st};
        do
            @(posedge clk);
        while (!s_axis_tready);
        grow_extent(st, ct, off, sz, res);
        expected_extents.push_back(res);
    endtask

    // Wait for all results, then write the usable block count.
    task automatic set_block_limit(input logic [12:0] value);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        wait (expected_extents.size() == 0);
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we      = 1'b0;
        block_limit = value;
        phases_run++;
    endtask

    // Choose a write end so that it covers exactly the target block count.
    task automatic write_span(input int target, output logic [24:0] off,
                              output logic [24:0] sz);
        int last_byte;
        if (target <= 0) begin
            off = 25'($urandom_range(0, 4096));
            sz  = 25'd0;
            if (off > 0)
                off = 25'd0;
            return;
        end
        last_byte = (target - 1) * 4096 + $urandom_range(1, 4096);
        off = 25'($urandom_range(0, last_byte));
        sz  = 25'(last_byte - int'(off));
    endtask

    task automatic test_directed();
        extent_result_t res;
        calm = 1'b1;
        send_request(12'd0, 13'd0, 25'd0, 25'd0, res);          // nothing to write
        send_request(12'd0, 13'd0, 25'd0, 25'd1, res);          // empty file gets one block
        send_request(12'd0, 13'd1, 25'd4095, 25'd1, res);       // ends on a block boundary
        send_request(12'd0, 13'd1, 25'd4096, 25'd1, res);       // one byte into the next block
        send_request(12'd10, 13'd0, 25'd0, 25'd4096, res);
        send_request(12'd0, 13'd2, 25'd0, 25'd20000, res);      // grow in place to five
        send_request(12'd4, 13'd1, 25'd0, 25'd8192, res);       // next block free: grow in place
        send_request(12'd0, 13'd0, 25'd0, 25'd16777216, res);   // whole map: no space
        send_request(12'd4095, 13'd8191, 25'h1FFFFFF, 25'h1FFFFFF, res);
        send_request(12'd4095, 13'd8191, 25'd0, 25'd1, res);    // wide extent, unchanged
        send_request(12'd4095, 13'd1, 25'd0, 25'd8192, res);    // grow runs past the end
        send_request(12'd0, 13'd4096, 25'd0, 25'd16777216, res);
        send_request(12'd100, 13'd4000, 25'd16777216, 25'd0, res); // whole map needed: no space
        send_request(12'd2048, 13'd0, 25'd0, 25'd16777216, res);
        send_request(12'd0, 13'd0, 25'd0, 25'd4097, res);
        send_request(12'd4000, 13'd200, 25'd0, 25'd1000000, res);
        calm = 1'b0;
    endtask

    // Well-formed growth of tracked files, with some noise words mixed in.
    task automatic test_random_phase(input int items);
        extent_result_t res;
        logic [24:0]    off;
        logic [24:0]    sz;
        int             f;
        int             target;
        for (int f0 = 0; f0 < NUM_FILES; f0++) begin
            file_start[f0] = 12'($urandom);
            file_count[f0] = 13'd0;
        end
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(99) < 25) begin
                off = ($urandom_range(1) == 1) ? 25'($urandom) : 25'($urandom_range(0, 65536));
                sz  = ($urandom_range(1) == 1) ? 25'($urandom) : 25'($urandom_range(0, 65536));
                send_request(12'($urandom), 13'($urandom), off, sz, res);
            end
            else begin
                f = $urandom_range(0, NUM_FILES - 1);
                if ($urandom_range(99) < 8) begin
                    file_start[f] = 12'($urandom);
                    file_count[f] = 13'd0;
                end
                target = int'(file_count[f]) + $urandom_range(0, 6) - 1;
                write_span(target, off, sz);
                send_request(file_start[f], file_count[f], off, sz, res);
                if (res.status == ceg_pkg::ST_GROWN || res.status == ceg_pkg::ST_RELOCATED) begin
                    file_start[f] = res.new_start;
                    file_count[f] = res.new_count;
                end
            end
        end
    endtask

    // Sweep the usable block count, extremes included.
    task automatic test_limit_sweep();
        logic [12:0] limits [10];
        limits = '{13'd4096, 13'd0, 13'd1, 13'd8191, 13'd9, 13'd100,
                   13'd300, 13'd4095, 13'd64, 13'd4096};
        foreach (limits[i]) begin
            set_block_limit(limits[i]);
            calm = (i == 5);
            test_random_phase((limits[i] >= 4095) ? 150 : 200);
        end
        calm = 1'b0;
        set_block_limit(13'($urandom_range(1, 8191)));
        test_random_phase(100);
    endtask

    // Receiver stalls, drawn at each falling edge.
    always @(negedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // Check each result word against the oldest expected extent.
    always @(posedge clk) begin
        extent_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_extents.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word %h", $time, m_axis_tdata);
            end
            else begin
                want = expected_extents.pop_front();
                status_hits[want.status]++;
                if (m_axis_tdata[1:0] !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_axis_tdata[1:0]);
                end
                if (m_axis_tdata[13:2] !== want.new_start) begin
                    errors++;
                    $display("%0t: new_start expected %0d actual %0d",
                             $time, want.new_start, m_axis_tdata[13:2]);
                end
                if (m_axis_tdata[26:14] !== want.new_count) begin
                    errors++;
                    $display("%0t: new_count expected %0d actual %0d",
                             $time, want.new_count, m_axis_tdata[26:14]);
                end
                if (m_axis_tdata[31:27] !== 5'd0) begin
                    errors++;
                    $display("%0t: pad bits expected 0 actual %h", $time, m_axis_tdata[31:27]);
                end
            end
        end
    end

    // Watchdog: end the run when no word moves for too long.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_MAX);
            $display("contiguous_extent_grow_allocator_core_tb failed");
            $finish;
        end
    end

    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 13'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        calm          = 1'b0;
        errors        = 0;
        results_seen  = 0;
        phases_run    = 0;
        stall_cycles  = 0;
        status_hits   = '{0, 0, 0, 0};
        block_limit   = 13'(ceg_pkg::CFG_RESET);
        foreach (used_map[i])
            used_map[i] = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_limit_sweep();

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        wait (expected_extents.size() == 0);
        repeat (50) @(posedge clk);

        $display("Ran %0d requests over %0d limit settings: %0d unchanged, %0d grown,",
                 results_seen, phases_run, status_hits[0], status_hits[1]);
        $display("%0d relocated, %0d out of space; %0d mismatches.",
                 status_hits[2], status_hits[3], errors);
        if (errors == 0 && expected_extents.size() == 0)
            $display("contiguous_extent_grow_allocator_core_tb passed");
        else
            $display("contiguous_extent_grow_allocator_core_tb failed");
        $finish;
    end

endmodule
